/* rtl/core/tsps_pkg.sv */
// Shared types and constants for the temperature sensor poll sequencer.
// Holds the item mode and command codes, register indexes and the configuration struct.
// No dependencies.
package tsps_pkg;

  localparam int unsigned CFG_TIMER_W = 24;
  localparam int unsigned CFG_TEMP_W  = 16;
  localparam int unsigned CFG_IDX_W   = 3;

  typedef enum logic [1:0] {
    MODE_TICK    = 2'd0,
    MODE_PROBE   = 2'd1,
    MODE_READING = 2'd2,
    MODE_UNUSED  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    CMD_NONE       = 2'd0,
    CMD_PROBE      = 2'd1,
    CMD_START_CONV = 2'd2,
    CMD_READ_TEMP  = 2'd3
  } cmd_t;

  localparam logic [CFG_IDX_W-1:0] REG_READ_INTERVAL   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CONVERSION_WAIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INVALID_TIMEOUT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_MIN        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_MAX        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DISCONNECTED    = 3'd5;

  localparam logic [CFG_TIMER_W-1:0] RST_READ_INTERVAL   = 24'd1000;
  localparam logic [CFG_TIMER_W-1:0] RST_CONVERSION_WAIT = 24'd800;
  localparam logic [CFG_TIMER_W-1:0] RST_INVALID_TIMEOUT = 24'd10000;
  localparam logic signed [CFG_TEMP_W-1:0] RST_TEMP_MIN     = -16'sd880;
  localparam logic signed [CFG_TEMP_W-1:0] RST_TEMP_MAX     = 16'sd2000;
  localparam logic signed [CFG_TEMP_W-1:0] RST_DISCONNECTED = -16'sd2032;

  typedef struct packed {
    logic        [CFG_TIMER_W-1:0] read_interval_ms;
    logic        [CFG_TIMER_W-1:0] conversion_wait_ms;
    logic        [CFG_TIMER_W-1:0] invalid_timeout_ms;
    logic signed [CFG_TEMP_W-1:0]  temp_min;
    logic signed [CFG_TEMP_W-1:0]  temp_max;
    logic signed [CFG_TEMP_W-1:0]  disconnected_code;
  } cfg_t;

endpackage

/* rtl/core/temp_sensor_poll_sequencer_unit.sv */
// Top level of the temperature sensor poll sequencer: input register, state update, result register.
// Depends on tsps_pkg and tsps_cfg_regs.
//
// channel | ports                       | direction | content
// in      | in_tvalid/tready/tdata/tuser | slave     | tick, probe result or raw reading
// out     | out_tvalid/tready/tdata      | master    | command and status after each item
// cfg     | cfg_valid/ready/index/data   | slave     | register writes, always ready
//
// One item enters per cycle while in_tready is high; its result passes through the
// input register, then the result register.
// Every item gives exactly one result. A stalled output holds the result register
// and the input register, and in_tready falls only when both are full.
// rst_n is synchronous; it empties both stages and restores the sensor state and registers.
module temp_sensor_poll_sequencer_unit import tsps_pkg::*; #(
  parameter int unsigned TIMER_WIDTH = 24,
  parameter int unsigned TEMP_WIDTH  = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [23:0]            in_tdata,   // device_present[0], raw_reading[16:1], zero pad
  input  logic [1:0]             in_tuser,   // mode[1:0]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [23:0]            out_tdata,  // command[1:0], last_temperature[17:2],
                                             // reading_valid[18], sensor_present[19],
                                             // converting[20], zero pad
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_TIMER_W-1:0] cfg_data
);

  localparam int unsigned CW = (TIMER_WIDTH > CFG_TIMER_W) ? TIMER_WIDTH : CFG_TIMER_W;
  localparam int unsigned SH = CFG_TEMP_W - TEMP_WIDTH;

  cfg_t cfg;

  tsps_cfg_regs #(
    .TEMP_WIDTH (TEMP_WIDTH)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Input register.
  logic                  in_vld_r;
  mode_t                 mode_r;
  logic                  dev_present_r;
  logic [CFG_TEMP_W-1:0] raw_r;

  // Sensor state.
  logic                          present_r, present_nxt;
  logic                          busy_r, busy_nxt;
  logic                          valid_r, valid_nxt;
  logic signed [CFG_TEMP_W-1:0]  stored_r, stored_nxt;
  logic [TIMER_WIDTH-1:0]        since_action_r, since_action_nxt;
  logic [TIMER_WIDTH-1:0]        since_good_r, since_good_nxt;

  // Result register.
  logic                  out_vld_r;
  cmd_t                  cmd_r, cmd_nxt;
  logic [CFG_TEMP_W-1:0] temp_out_r;
  logic                  valid_out_r, present_out_r, busy_out_r;

  logic adv, load;
  logic [TIMER_WIDTH-1:0]       act_inc, good_inc;
  logic [CW-1:0]                act_x, good_x, interval_x, wait_x, timeout_x;
  logic signed [CFG_TEMP_W-1:0] rd_up, rd_val;
  logic                         rd_bad;

  assign adv       = !out_vld_r || out_tready;
  assign load      = in_vld_r && adv;
  assign in_tready = !in_vld_r || adv;

  assign act_inc  = (&since_action_r) ? since_action_r : since_action_r + 1'b1;
  assign good_inc = (&since_good_r) ? since_good_r : since_good_r + 1'b1;

  assign act_x      = CW'(act_inc);
  assign good_x     = CW'(good_inc);
  assign interval_x = CW'(cfg.read_interval_ms);
  assign wait_x     = CW'(cfg.conversion_wait_ms);
  assign timeout_x  = CW'(cfg.invalid_timeout_ms);

  assign rd_up  = raw_r <<< SH;
  assign rd_val = rd_up >>> SH;
  assign rd_bad = (rd_val == cfg.disconnected_code) || (rd_val < cfg.temp_min)
                  || (rd_val > cfg.temp_max);

  always_comb begin
    present_nxt      = present_r;
    busy_nxt         = busy_r;
    valid_nxt        = valid_r;
    stored_nxt       = stored_r;
    since_action_nxt = since_action_r;
    since_good_nxt   = since_good_r;
    cmd_nxt          = CMD_NONE;
    unique case (mode_r)
      MODE_TICK: begin
        since_action_nxt = act_inc;
        since_good_nxt   = good_inc;
        if (!present_r) begin
          if (valid_r && (good_x > timeout_x)) begin
            valid_nxt = 1'b0;
          end
          if (act_x > interval_x) begin
            since_action_nxt = '0;
            cmd_nxt          = CMD_PROBE;
          end
        end else if (!busy_r) begin
          if (act_x >= interval_x) begin
            busy_nxt         = 1'b1;
            since_action_nxt = '0;
            cmd_nxt          = CMD_START_CONV;
          end
        end else if (act_x >= wait_x) begin
          busy_nxt         = 1'b0;
          since_action_nxt = '0;
          cmd_nxt          = CMD_READ_TEMP;
        end
      end
      MODE_PROBE: begin
        present_nxt = dev_present_r;
        if (dev_present_r) begin
          since_action_nxt = '0;
        end
      end
      MODE_READING: begin
        if (rd_bad) begin
          present_nxt = 1'b0;
        end else begin
          stored_nxt     = rd_val;
          valid_nxt      = 1'b1;
          since_good_nxt = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r       <= 1'b0;
      out_vld_r      <= 1'b0;
      present_r      <= 1'b0;
      busy_r         <= 1'b0;
      valid_r        <= 1'b0;
      stored_r       <= '0;
      since_action_r <= '1;
      since_good_r   <= '0;
    end else begin
      if (in_tready) begin
        in_vld_r <= in_tvalid;
      end
      if (load) begin
        out_vld_r      <= 1'b1;
        present_r      <= present_nxt;
        busy_r         <= busy_nxt;
        valid_r        <= valid_nxt;
        stored_r       <= stored_nxt;
        since_action_r <= since_action_nxt;
        since_good_r   <= since_good_nxt;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      mode_r        <= mode_t'(in_tuser);
      dev_present_r <= in_tdata[0];
      raw_r         <= in_tdata[16:1];
    end
    if (load) begin
      cmd_r         <= cmd_nxt;
      temp_out_r    <= stored_nxt;
      valid_out_r   <= valid_nxt;
      present_out_r <= present_nxt;
      busy_out_r    <= busy_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {3'b000, busy_out_r, present_out_r, valid_out_r, temp_out_r, cmd_r};

  a_cmd_clears_timer: assert property (@(posedge clk) disable iff (!rst_n)
    (load && cmd_nxt != CMD_NONE) |=> (since_action_r == '0))
    else $error("Issued command did not restart the action timer.");

  a_start_conv_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && cmd_r == CMD_START_CONV) |-> (busy_out_r && present_out_r))
    else $error("Start conversion without present and converting flags.");

  a_read_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && cmd_r == CMD_READ_TEMP) |-> (!busy_out_r && present_out_r))
    else $error("Read command with inconsistent flags.");

  a_probe_absent: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && cmd_r == CMD_PROBE) |-> !present_out_r)
    else $error("Probe command while sensor is marked present.");

  a_good_reading: assert property (@(posedge clk) disable iff (!rst_n)
    (load && mode_r == MODE_READING && !rd_bad) |=> (valid_r && since_good_r == '0))
    else $error("Good reading not stored as current.");

endmodule

/* rtl/core/tsps_cfg_regs.sv */
// Configuration register file of the poll sequencer.
// Depends on tsps_pkg for the register indexes, reset values and cfg_t.
module tsps_cfg_regs import tsps_pkg::*; #(
  parameter int unsigned TEMP_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_TIMER_W-1:0] cfg_data,
  output cfg_t                   cfg
);

  localparam int unsigned SH = CFG_TEMP_W - TEMP_WIDTH;

  cfg_t                         cfg_r;
  logic signed [CFG_TEMP_W-1:0] temp_up;
  logic signed [CFG_TEMP_W-1:0] temp_val;

  // Temperature registers take the low TEMP_WIDTH bits, sign extended.
  assign temp_up  = cfg_data[CFG_TEMP_W-1:0] <<< SH;
  assign temp_val = temp_up >>> SH;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.read_interval_ms   <= RST_READ_INTERVAL;
      cfg_r.conversion_wait_ms <= RST_CONVERSION_WAIT;
      cfg_r.invalid_timeout_ms <= RST_INVALID_TIMEOUT;
      cfg_r.temp_min           <= RST_TEMP_MIN;
      cfg_r.temp_max           <= RST_TEMP_MAX;
      cfg_r.disconnected_code  <= RST_DISCONNECTED;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_READ_INTERVAL:   cfg_r.read_interval_ms   <= cfg_data;
        REG_CONVERSION_WAIT: cfg_r.conversion_wait_ms <= cfg_data;
        REG_INVALID_TIMEOUT: cfg_r.invalid_timeout_ms <= cfg_data;
        REG_TEMP_MIN:        cfg_r.temp_min           <= temp_val;
        REG_TEMP_MAX:        cfg_r.temp_max           <= temp_val;
        REG_DISCONNECTED:    cfg_r.disconnected_code  <= temp_val;
        default: ;
      endcase
    end
  end

endmodule
